@@ rtl/tdb_pkg.sv @@
// Shared types and constants for the tick-to-OHLC delta bar block.
// Used by tdb_front, tdb_fifo, tdb_back and the top level.
package tdb_pkg;

  localparam int EpochW = 40;
  localparam int PriceW = 32;
  localparam int MidW   = 33;
  localparam int CntW   = 32;
  localparam int CfgW   = 20;
  localparam int RatioW = 22;
  localparam int FracW  = 20;
  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgGapIdx = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBarIdx = 1'b1;

  localparam logic [CfgW-1:0] GapReset = CfgW'(30 * 60);
  localparam logic [CfgW-1:0] BarReset = CfgW'(15 * 60);

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_END  = 1'b1
  } op_e;

  // one classified beat handed from front to back
  typedef struct packed {
    op_e               op;
    logic [EpochW-1:0] epoch;
    logic [EpochW-1:0] bucket;
    logic [MidW-1:0]   mid;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

@@ rtl/tdb_front.sv @@
// Front end: accepts beats, drops bad ticks, aligns the tick time to the bar
// with a bit-serial remainder unit. Depends on tdb_pkg.
module tdb_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       operation_i,
  input  logic [tdb_pkg::EpochW-1:0] epoch_i,
  input  logic [tdb_pkg::PriceW-1:0] bid_i,
  input  logic [tdb_pkg::PriceW-1:0] ask_i,
  input  logic [tdb_pkg::CfgW-1:0]   bar_seconds_i,
  input  tdb_pkg::fifo_stat_t        fifo_stat_i,
  output logic                       push_o,
  output tdb_pkg::item_t             item_o
);
  import tdb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_PUSH
  } state_e;

  localparam int CntBits = $clog2(EpochW + 1);

  state_e              state_q, state_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [CfgW:0]       rem_q, rem_d;
  logic [EpochW-1:0]   dvd_q, dvd_d;
  logic [EpochW-1:0]   epoch_q, epoch_d;
  logic [MidW-1:0]     mid_q, mid_d;
  logic [CfgW-1:0]     len_q, len_d;
  logic                accept;
  logic                keep;
  logic [CfgW:0]       trial;

  assign in_stall_o = (state_q != S_IDLE) || fifo_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign keep       = (ask_i > bid_i) && (bid_i != '0);
  assign trial      = {rem_q[CfgW-1:0], dvd_q[EpochW-1]};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    epoch_d = epoch_q;
    mid_d   = mid_q;
    len_d   = len_q;
    push_o  = 1'b0;
    item_o  = '0;
    case (state_q)
      S_IDLE: begin
        if (accept && operation_i == OP_END) begin
          push_o    = 1'b1;
          item_o.op = OP_END;
        end else if (accept && keep) begin
          epoch_d = epoch_i;
          dvd_d   = epoch_i;
          rem_d   = '0;
          mid_d   = {1'b0, bid_i} + {1'b0, ask_i};
          len_d   = (bar_seconds_i == '0) ? CfgW'(1) : bar_seconds_i;
          cnt_d   = CntBits'(EpochW);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = (trial >= {1'b0, len_q}) ? trial - {1'b0, len_q} : trial;
        dvd_d = {dvd_q[EpochW-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        push_o        = 1'b1;
        item_o.op     = OP_TICK;
        item_o.epoch  = epoch_q;
        item_o.bucket = epoch_q - {{(EpochW-CfgW){1'b0}}, rem_q[CfgW-1:0]};
        item_o.mid    = mid_q;
        state_d       = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    epoch_q <= epoch_d;
    mid_q   <= mid_d;
    len_q   <= len_d;
  end

endmodule

@@ rtl/tdb_fifo.sv @@
// Two-entry queue between front and back ends.
// Depends on tdb_pkg.
module tdb_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tdb_pkg::item_t      item_i,
  input  logic                pop_i,
  output tdb_pkg::item_t      item_o,
  output tdb_pkg::fifo_stat_t stat_o
);
  import tdb_pkg::*;

  item_t       mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;

  assign item_o       = mem_q[rp_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= item_i;
  end

endmodule

@@ rtl/tdb_back.sv @@
// Back end: bar state, tick rule, bar close and the serial ratio divider.
// Depends on tdb_pkg.
module tdb_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tdb_pkg::fifo_stat_t        fifo_stat_i,
  input  tdb_pkg::item_t             item_i,
  output logic                       pop_o,
  input  logic [tdb_pkg::CfgW-1:0]   gap_limit_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tdb_pkg::EpochW-1:0] bar_start_o,
  output logic [tdb_pkg::CntW-1:0]   seg_num_o,
  output logic [tdb_pkg::MidW-1:0]   open_mid_o,
  output logic [tdb_pkg::MidW-1:0]   high_mid_o,
  output logic [tdb_pkg::MidW-1:0]   low_mid_o,
  output logic [tdb_pkg::MidW-1:0]   close_mid_o,
  output logic [tdb_pkg::CntW-1:0]   tick_count_o,
  output logic [tdb_pkg::CntW-1:0]   buy_count_o,
  output logic [tdb_pkg::CntW-1:0]   sell_count_o,
  output logic [tdb_pkg::CntW-1:0]   neutral_count_o,
  output logic [tdb_pkg::MidW-1:0]   delta_o,
  output logic [tdb_pkg::RatioW-1:0] ratio_o
);
  import tdb_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_DIV
  } state_e;

  localparam int QW   = FracW + 1;
  localparam int QCW  = $clog2(QW + 1);
  localparam int RemW = CntW + 2;

  state_e             state_q;
  logic               active_q, havep_q, pmv_q;
  logic [EpochW-1:0]  start_q, ptime_q;
  logic [MidW-1:0]    open_q, high_q, low_q, close_q, pmid_q;
  logic [CntW-1:0]    ticks_q, buy_q, sell_q, neut_q, bseg_q, segc_q;
  logic               ovalid_q;
  logic [EpochW-1:0]  o_start_q;
  logic [CntW-1:0]    o_seg_q, o_ticks_q, o_buy_q, o_sell_q, o_neut_q;
  logic [MidW-1:0]    o_open_q, o_high_q, o_low_q, o_close_q, o_delta_q;
  logic [RatioW-1:0]  o_ratio_q;
  logic               neg_q;
  logic [RemW-1:0]    rem_q;
  logic [MidW-1:0]    den_q;
  logic [QW-1:0]      quo_q;
  logic [QCW-1:0]     qcnt_q;

  logic               pop, is_end, gap, diff, closing, emit, fresh;
  logic [EpochW-1:0]  elapsed;
  logic               up, dn;
  logic               s_neg;
  logic [CntW-1:0]    s_mag;
  logic [MidW-1:0]    s_den;
  logic               qbit;
  logic [RemW-1:0]    rem_sub;
  logic [QW-1:0]      quo_next;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

  assign pop     = !fifo_stat_i.empty && (state_q == S_IDLE) && !ovalid_q;
  assign pop_o   = pop;
  assign is_end  = (item_i.op == OP_END);
  assign elapsed = item_i.epoch - ptime_q;
  assign gap     = havep_q && (item_i.epoch > ptime_q) &&
                   (elapsed > {{(EpochW-CfgW){1'b0}}, gap_limit_i});
  assign diff    = start_q != item_i.bucket;
  assign closing = is_end ? active_q : (active_q && (gap || diff));
  assign emit    = is_end ? active_q : (active_q && diff);
  assign fresh   = !active_q || closing;
  assign up      = !gap && pmv_q && (item_i.mid > pmid_q);
  assign dn      = !gap && pmv_q && (item_i.mid < pmid_q);
  assign s_neg   = sell_q > buy_q;
  assign s_mag   = s_neg ? sell_q - buy_q : buy_q - sell_q;
  assign s_den   = {1'b0, buy_q} + {1'b0, sell_q};

  assign qbit     = rem_q >= {1'b0, den_q};
  assign rem_sub  = qbit ? rem_q - {1'b0, den_q} : rem_q;
  assign quo_next = {quo_q[QW-2:0], qbit};

  assign out_valid_o     = ovalid_q;
  assign bar_start_o     = o_start_q;
  assign seg_num_o       = o_seg_q;
  assign open_mid_o      = o_open_q;
  assign high_mid_o      = o_high_q;
  assign low_mid_o       = o_low_q;
  assign close_mid_o     = o_close_q;
  assign tick_count_o    = o_ticks_q;
  assign buy_count_o     = o_buy_q;
  assign sell_count_o    = o_sell_q;
  assign neutral_count_o = o_neut_q;
  assign delta_o         = o_delta_q;
  assign ratio_o         = o_ratio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      active_q <= 1'b0;
      havep_q  <= 1'b0;
      pmv_q    <= 1'b0;
      ptime_q  <= '0;
      pmid_q   <= '0;
      segc_q   <= '0;
      start_q  <= '0;
      qcnt_q   <= '0;
    end else begin
      if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (pop && emit) begin
            if (s_den == '0) begin
              ovalid_q <= 1'b1;
            end else begin
              state_q <= S_DIV;
              qcnt_q  <= QCW'(QW);
            end
          end
          if (pop && is_end) begin
            active_q <= 1'b0;
          end else if (pop) begin
            active_q <= 1'b1;
            havep_q  <= 1'b1;
            pmv_q    <= 1'b1;
            ptime_q  <= item_i.epoch;
            pmid_q   <= item_i.mid;
            if (gap) segc_q <= segc_q + 1'b1;
            if (fresh) start_q <= item_i.bucket;
          end
        end
        S_DIV: begin
          qcnt_q <= qcnt_q - 1'b1;
          if (qcnt_q == QCW'(1)) begin
            state_q  <= S_IDLE;
            ovalid_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // bar payload and output snapshot
  always_ff @(posedge clk_i) begin
    if (pop && !is_end) begin
      if (fresh) begin
        open_q  <= item_i.mid;
        high_q  <= item_i.mid;
        low_q   <= item_i.mid;
        ticks_q <= CntW'(1);
        buy_q   <= CntW'(up);
        sell_q  <= CntW'(dn);
        neut_q  <= CntW'(!up && !dn);
        bseg_q  <= gap ? segc_q + 1'b1 : segc_q;
      end else begin
        if (item_i.mid > high_q) high_q <= item_i.mid;
        if (item_i.mid < low_q)  low_q  <= item_i.mid;
        ticks_q <= sat_inc(ticks_q);
        if (up)      buy_q  <= sat_inc(buy_q);
        else if (dn) sell_q <= sat_inc(sell_q);
        else         neut_q <= sat_inc(neut_q);
      end
      close_q <= item_i.mid;
    end
    if (state_q == S_IDLE && pop && emit) begin
      o_start_q <= start_q;
      o_seg_q   <= bseg_q;
      o_open_q  <= open_q;
      o_high_q  <= high_q;
      o_low_q   <= low_q;
      o_close_q <= close_q;
      o_ticks_q <= ticks_q;
      o_buy_q   <= buy_q;
      o_sell_q  <= sell_q;
      o_neut_q  <= neut_q;
      o_delta_q <= s_neg ? MidW'(0) - {1'b0, s_mag} : {1'b0, s_mag};
      o_ratio_q <= '0;
      neg_q     <= s_neg;
      den_q     <= s_den;
      rem_q     <= {2'b00, s_mag};
      quo_q     <= '0;
    end else if (state_q == S_DIV) begin
      quo_q <= quo_next;
      rem_q <= {rem_sub[RemW-2:0], 1'b0};
      if (qcnt_q == QCW'(1)) begin
        o_ratio_q <= neg_q ? RatioW'(0) - {1'b0, quo_next} : {1'b0, quo_next};
      end
    end
  end

endmodule

@@ rtl/tick_to_ohlc_delta_bars.sv @@
// Top level of the tick-to-OHLC delta bar block: config registers, front end,
// queue and back end. Depends on tdb_pkg, tdb_front, tdb_fifo, tdb_back.
//
// Price ticks are grouped into time bars aligned to bar_seconds; a bar is
// emitted when a tick falls in a different bar or on an end-of-stream beat, and
// a bar cut by a time gap above the gap limit is dropped unless the gap tick
// falls in a different bar. In the front end a kept tick passes the bit-serial
// remainder unit that aligns the tick time (one bit of the 40-bit epoch per
// cycle); bad ticks are dropped. A bar close runs the ratio divider in the back
// end (not when buy plus sell is zero), and the back end waits while a finished
// bar sits unread on the output; a two-beat queue lets the front keep working.
module tick_to_ohlc_delta_bars (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [tdb_pkg::EpochW-1:0]  epoch_i,
  input  logic [tdb_pkg::PriceW-1:0]  bid_i,
  input  logic [tdb_pkg::PriceW-1:0]  ask_i,
  input  logic                        cfg_we_i,
  input  logic [tdb_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tdb_pkg::CfgW-1:0]    cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tdb_pkg::EpochW-1:0]  bar_start_o,
  output logic [tdb_pkg::CntW-1:0]    seg_num_o,
  output logic [tdb_pkg::MidW-1:0]    open_mid_o,
  output logic [tdb_pkg::MidW-1:0]    high_mid_o,
  output logic [tdb_pkg::MidW-1:0]    low_mid_o,
  output logic [tdb_pkg::MidW-1:0]    close_mid_o,
  output logic [tdb_pkg::CntW-1:0]    tick_count_o,
  output logic [tdb_pkg::CntW-1:0]    buy_count_o,
  output logic [tdb_pkg::CntW-1:0]    sell_count_o,
  output logic [tdb_pkg::CntW-1:0]    neutral_count_o,
  output logic [tdb_pkg::MidW-1:0]    delta_o,
  output logic [tdb_pkg::RatioW-1:0]  ratio_o
);
  import tdb_pkg::*;

  logic [CfgW-1:0] gap_q, bar_q;
  logic            push, pop;
  item_t           push_item, pop_item;
  fifo_stat_t      fstat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= GapReset;
      bar_q <= BarReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgGapIdx: gap_q <= cfg_data_i;
        CfgBarIdx: bar_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tdb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .epoch_i       (epoch_i),
    .bid_i         (bid_i),
    .ask_i         (ask_i),
    .bar_seconds_i (bar_q),
    .fifo_stat_i   (fstat),
    .push_o        (push),
    .item_o        (push_item)
  );

  tdb_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (pop_item),
    .stat_o (fstat)
  );

  tdb_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fifo_stat_i     (fstat),
    .item_i          (pop_item),
    .pop_o           (pop),
    .gap_limit_i     (gap_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .bar_start_o     (bar_start_o),
    .seg_num_o       (seg_num_o),
    .open_mid_o      (open_mid_o),
    .high_mid_o      (high_mid_o),
    .low_mid_o       (low_mid_o),
    .close_mid_o     (close_mid_o),
    .tick_count_o    (tick_count_o),
    .buy_count_o     (buy_count_o),
    .sell_count_o    (sell_count_o),
    .neutral_count_o (neutral_count_o),
    .delta_o         (delta_o),
    .ratio_o         (ratio_o)
  );

endmodule
